### rtl/core/icr_pkg.sv
// Shared types and constants for the interrupt controller register block.
// No dependencies; imported by icr_ffs and interrupt_controller_registers_top.
`default_nettype none

package icr_pkg;

  localparam logic [31:0] DIST_BASE  = 32'h0800_0000;
  localparam logic [31:0] CPU_BASE   = 32'h0801_0000;
  localparam int          NUM_LINES  = 256;
  localparam int          LINE_W     = 8;
  localparam int          NUM_WORDS  = NUM_LINES / 32;
  localparam int          WORD_W     = 3;
  localparam int          WIN_W      = 12;

  localparam logic [31:0] TYPE_VALUE  = 32'h0000_001F;
  localparam logic [31:0] PMASK_VALUE = 32'h0000_00FF;
  localparam logic [31:0] SPURIOUS    = 32'd1023;

  // distributor offsets
  localparam logic [WIN_W-1:0] OFF_DCTL    = 12'h000;
  localparam logic [WIN_W-1:0] OFF_TYPE    = 12'h004;
  localparam logic [WIN_W-1:0] OFF_ISEN    = 12'h100;
  localparam logic [WIN_W-1:0] OFF_ICEN    = 12'h180;
  localparam logic [WIN_W-1:0] OFF_ISPEND  = 12'h200;
  localparam logic [WIN_W-1:0] OFF_ICPEND  = 12'h280;
  localparam logic [WIN_W-1:0] PRIO_OFFSET = 12'h400;
  localparam logic [WIN_W-1:0] PRIO_END    = 12'(32'h400 + NUM_LINES);

  // cpu interface offsets
  localparam logic [WIN_W-1:0] OFF_CCTL = 12'h000;
  localparam logic [WIN_W-1:0] OFF_PMR  = 12'h004;
  localparam logic [WIN_W-1:0] OFF_IAR  = 12'h00C;
  localparam logic [WIN_W-1:0] OFF_EOI  = 12'h010;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_RAISE = 2'd2,
    ACT_LOWER = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [7:0]  line_number;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        status;
  } out_t;

  typedef struct packed {
    logic       found;
    logic [4:0] bit_idx;
  } ffs_t;

  function automatic logic [31:0] bit_mask(input logic [4:0] b);
    bit_mask = 32'd1 << b;
  endfunction

endpackage

`default_nettype wire

### rtl/core/icr_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none

module icr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/icr_ffs.sv
// Find-first-set unit used by the acknowledge scan, one 32-bit word per use.
// Depends on icr_pkg.
`default_nettype none

module icr_ffs (
  input  wire logic [31:0] word,
  output icr_pkg::ffs_t    res
);
  import icr_pkg::*;

  always_comb begin
    res.found   = |word;
    res.bit_idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (word[i]) begin
        res.bit_idx = 5'(i);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/interrupt_controller_registers_top.sv
// Interrupt controller register block: decode, state and acknowledge sequencer.
// Depends on icr_pkg, icr_ram, icr_ffs.
//
//   channel | ports                          | transaction fields
//   --------+--------------------------------+---------------------------------------
//   input   | in_valid, in_stall, in_data    | action, address, write_data, line_number
//   result  | out_valid, out_stall, out_data | read_data, status
//
// Each transaction steps through accept, decode and output; priority reads add a RAM
// read step; acknowledge reads with both control enables set scan one pending word per
// cycle through the find-first unit; with either enable clear they do not scan.
// Reset clears controls, enables, pending; priority bytes read 0 until written
// (per-entry valid bits), so no clearing pass is needed.
// in_stall is high from accept until the result transaction completes.
`default_nettype none

module interrupt_controller_registers_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire icr_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output icr_pkg::out_t      out_data
);
  import icr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_SCAN = 5'b00100,
    S_PRIO = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  in_t                  req_r, req_nxt;
  out_t                 out_r, out_nxt;
  logic [31:0]          dctl_r, dctl_nxt;
  logic [31:0]          cctl_r, cctl_nxt;
  logic [31:0]          en_r, en_nxt;
  logic [31:0]          pend_r [NUM_WORDS];
  logic [WORD_W-1:0]    scan_r, scan_nxt;
  logic [NUM_LINES-1:0] vld_r;

  logic [WORD_W-1:0]    idx;
  logic [31:0]          pend_rd;
  logic                 pend_we;
  logic [31:0]          pend_wd;
  logic                 ram_we;
  logic                 ram_re;
  logic [LINE_W-1:0]    prio_idx;
  logic [7:0]           ram_q;
  logic [31:0]          scan_word;
  ffs_t                 ffs;

  logic [WIN_W-1:0]     off;
  logic                 dist_hit;
  logic                 cpu_hit;
  logic                 wr;
  logic                 is_line;
  logic                 is_eoi;

  assign off      = req_r.address[WIN_W-1:0];
  assign dist_hit = req_r.address[31:WIN_W] == DIST_BASE[31:WIN_W];
  assign cpu_hit  = req_r.address[31:WIN_W] == CPU_BASE[31:WIN_W];
  assign wr       = req_r.action == ACT_WRITE;
  assign is_line  = req_r.action == ACT_RAISE || req_r.action == ACT_LOWER;
  assign is_eoi   = wr && cpu_hit && off == OFF_EOI;
  assign prio_idx = LINE_W'(off - PRIO_OFFSET);

  always_comb begin
    if (state_r == S_SCAN) begin
      idx = scan_r;
    end else if (is_line) begin
      idx = req_r.line_number[LINE_W-1:5];
    end else if (is_eoi) begin
      idx = req_r.write_data[LINE_W-1:5];
    end else begin
      idx = '0;
    end
  end

  assign pend_rd   = pend_r[idx];
  assign scan_word = pend_rd & ((scan_r == '0) ? en_r : 32'd0);

  icr_ffs u_ffs (
    .word (scan_word),
    .res  (ffs)
  );

  icr_ram #(
    .WIDTH (8),
    .DEPTH (NUM_LINES)
  ) u_prio_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (prio_idx),
    .wdata (req_r.write_data[7:0]),
    .re    (ram_re),
    .raddr (prio_idx),
    .rdata (ram_q)
  );

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    out_nxt   = out_r;
    dctl_nxt  = dctl_r;
    cctl_nxt  = cctl_r;
    en_nxt    = en_r;
    scan_nxt  = scan_r;
    pend_we   = 1'b0;
    pend_wd   = pend_rd;
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        out_nxt.read_data = '0;
        out_nxt.status    = 1'b0;
        state_nxt         = S_OUT;
        if (is_line) begin
          pend_we = 1'b1;
          if (req_r.action == ACT_RAISE) begin
            pend_wd = pend_rd | bit_mask(req_r.line_number[4:0]);
          end else begin
            pend_wd = pend_rd & ~bit_mask(req_r.line_number[4:0]);
          end
        end else if (dist_hit) begin
          unique case (off)
            OFF_DCTL: begin
              if (wr) dctl_nxt = req_r.write_data;
              else out_nxt.read_data = dctl_r;
            end
            OFF_TYPE: begin
              if (!wr) out_nxt.read_data = TYPE_VALUE;
            end
            OFF_ISEN: begin
              if (wr) en_nxt = en_r | req_r.write_data;
              else out_nxt.read_data = en_r;
            end
            OFF_ICEN: begin
              if (wr) en_nxt = en_r & ~req_r.write_data;
            end
            OFF_ISPEND: begin
              if (wr) begin
                pend_we = 1'b1;
                pend_wd = pend_rd | req_r.write_data;
              end else begin
                out_nxt.read_data = pend_rd;
              end
            end
            OFF_ICPEND: begin
              if (wr) begin
                pend_we = 1'b1;
                pend_wd = pend_rd & ~req_r.write_data;
              end
            end
            default: begin
              if (off >= PRIO_OFFSET && off < PRIO_END) begin
                if (wr) begin
                  ram_we = 1'b1;
                end else begin
                  ram_re    = 1'b1;
                  state_nxt = S_PRIO;
                end
              end else begin
                out_nxt.status = 1'b1;
              end
            end
          endcase
        end else if (cpu_hit) begin
          unique case (off)
            OFF_CCTL: begin
              if (wr) cctl_nxt = req_r.write_data;
              else out_nxt.read_data = cctl_r;
            end
            OFF_PMR: begin
              if (!wr) out_nxt.read_data = PMASK_VALUE;
            end
            OFF_IAR: begin
              if (!wr) begin
                if (dctl_r[0] && cctl_r[0]) begin
                  scan_nxt  = '0;
                  state_nxt = S_SCAN;
                end else begin
                  out_nxt.read_data = SPURIOUS;
                end
              end
            end
            OFF_EOI: begin
              if (wr && req_r.write_data < 32'(NUM_LINES)) begin
                pend_we = 1'b1;
                pend_wd = pend_rd & ~bit_mask(req_r.write_data[4:0]);
              end
            end
            default: begin
              out_nxt.status = 1'b1;
            end
          endcase
        end else begin
          out_nxt.status = 1'b1;
        end
      end
      S_SCAN: begin
        if (ffs.found) begin
          pend_we           = 1'b1;
          pend_wd           = pend_rd & ~bit_mask(ffs.bit_idx);
          out_nxt.read_data = 32'({scan_r, ffs.bit_idx});
          state_nxt         = S_OUT;
        end else if (scan_r == WORD_W'(NUM_WORDS - 1)) begin
          out_nxt.read_data = SPURIOUS;
          state_nxt         = S_OUT;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_PRIO: begin
        out_nxt.read_data = vld_r[prio_idx] ? 32'(ram_q) : 32'd0;
        state_nxt         = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dctl_r  <= '0;
      cctl_r  <= '0;
      en_r    <= '0;
      scan_r  <= '0;
      vld_r   <= '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        pend_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      dctl_r  <= dctl_nxt;
      cctl_r  <= cctl_nxt;
      en_r    <= en_nxt;
      scan_r  <= scan_nxt;
      if (pend_we) pend_r[idx] <= pend_wd;
      if (ram_we) vld_r[prio_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    out_r <= out_nxt;
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign out_data  = out_r;

endmodule

`default_nettype wire
